// File: hdl/tccs_pkg.sv
// shared types, codes and constants of the text console engine
// no dependencies; used by tccs_front, tccs_queue, tccs_back and the top
`default_nettype none
package tccs_pkg;

  localparam int MAX_COLUMNS_DEF = 128;
  localparam int MAX_ROWS_DEF    = 64;

  // command fields are sized for the largest supported geometry
  localparam int TGT_W = 8;

  // input actions
  localparam logic [2:0] ACT_PUT    = 3'd0;
  localparam logic [2:0] ACT_COLOUR = 3'd1;
  localparam logic [2:0] ACT_CLEAR  = 3'd2;
  localparam logic [2:0] ACT_MOVE   = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;

  // control characters
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // reset values
  localparam logic [7:0]  COLS_RESET = 8'd80;
  localparam logic [6:0]  ROWS_RESET = 7'd24;
  localparam logic [7:0]  ATTR_RESET = 8'h07;
  localparam logic [15:0] CELL_RESET = {ATTR_RESET, CH_SPACE};

  // register indexes
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  // classified operations
  localparam logic [3:0] OP_NOP    = 4'd0;
  localparam logic [3:0] OP_PUT    = 4'd1;
  localparam logic [3:0] OP_COLOUR = 4'd2;
  localparam logic [3:0] OP_CLEAR  = 4'd3;
  localparam logic [3:0] OP_MOVE   = 4'd4;
  localparam logic [3:0] OP_READ   = 4'd5;
  localparam logic [3:0] OP_LF     = 4'd6;
  localparam logic [3:0] OP_CR     = 4'd7;
  localparam logic [3:0] OP_BS     = 4'd8;
  localparam logic [3:0] OP_TAB    = 4'd9;

  typedef struct packed {
    logic [3:0]       op;
    logic [7:0]       chr;
    logic [7:0]       attr;
    logic [TGT_W-1:0] row;
    logic [TGT_W-1:0] col;
    logic             rd_ok;
  } cmd_t;

endpackage
`default_nettype wire

// File: hdl/tccs_cmd_if.sv
// input item channel of the text console engine
// depends on nothing
`default_nettype none
interface tccs_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic [7:0]        char_code;
  logic [3:0]        fg_colour;
  logic [3:0]        bg_colour;
  logic signed [8:0] target_row;
  logic signed [8:0] target_col;

  modport source (output valid, action, char_code, fg_colour, bg_colour, target_row,
                  target_col, input ready);
  modport sink (input valid, action, char_code, fg_colour, bg_colour, target_row,
                target_col, output ready);
endinterface
`default_nettype wire

// File: hdl/tccs_rsp_if.sv
// result channel of the text console engine
// depends on nothing
`default_nettype none
interface tccs_rsp_if;
  logic        valid;
  logic        ready;
  logic [5:0]  cursor_row;
  logic [6:0]  cursor_col;
  logic [12:0] cursor_linear;
  logic [15:0] cell_value;
  logic [7:0]  current_colour;

  modport source (output valid, cursor_row, cursor_col, cursor_linear, cell_value,
                  current_colour, input ready);
  modport sink (input valid, cursor_row, cursor_col, cursor_linear, cell_value,
                current_colour, output ready);
endinterface
`default_nettype wire

// File: hdl/tccs_ram.sv
// generic single write port, single read port ram with registered read
// depends on nothing
`default_nettype none
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hdl/tccs_front.sv
// front end: takes input items, classifies them and clamps the targets
// depends on tccs_pkg and tccs_cmd_if
`default_nettype none
module tccs_front #(
  parameter int MAX_COLUMNS = tccs_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tccs_pkg::MAX_ROWS_DEF
) (
  tccs_cmd_if.sink                              cmd,
  input  wire logic                             en,
  input  wire logic                             q_full,
  input  wire logic [$clog2(MAX_ROWS+1)-1:0]    eff_rows,
  input  wire logic [$clog2(MAX_COLUMNS+1)-1:0] eff_cols,
  output logic                                  push,
  output tccs_pkg::cmd_t                        push_data
);
  logic                       row_neg, col_neg;
  logic [tccs_pkg::TGT_W-1:0] trow, tcol;

  assign cmd.ready = en && !q_full;
  assign push      = cmd.valid && cmd.ready;

  assign row_neg = cmd.target_row[8];
  assign col_neg = cmd.target_col[8];
  assign trow    = cmd.target_row[7:0];
  assign tcol    = cmd.target_col[7:0];

  always_comb begin
    push_data      = '0;
    push_data.chr  = cmd.char_code;
    push_data.attr = {cmd.bg_colour, cmd.fg_colour};
    case (cmd.action)
      tccs_pkg::ACT_PUT: begin
        case (cmd.char_code)
          tccs_pkg::CH_NEWLINE:   push_data.op = tccs_pkg::OP_LF;
          tccs_pkg::CH_RETURN:    push_data.op = tccs_pkg::OP_CR;
          tccs_pkg::CH_BACKSPACE: push_data.op = tccs_pkg::OP_BS;
          tccs_pkg::CH_TAB:       push_data.op = tccs_pkg::OP_TAB;
          default:                push_data.op = tccs_pkg::OP_PUT;
        endcase
      end
      tccs_pkg::ACT_COLOUR: push_data.op = tccs_pkg::OP_COLOUR;
      tccs_pkg::ACT_CLEAR:  push_data.op = tccs_pkg::OP_CLEAR;
      tccs_pkg::ACT_MOVE:   push_data.op = tccs_pkg::OP_MOVE;
      tccs_pkg::ACT_READ:   push_data.op = tccs_pkg::OP_READ;
      default:              push_data.op = tccs_pkg::OP_NOP;
    endcase

    // clamp into the visible area; also used as the read address
    if (row_neg) begin
      push_data.row = '0;
    end else if (trow >= eff_rows) begin
      push_data.row = tccs_pkg::TGT_W'(eff_rows - 1'b1);
    end else begin
      push_data.row = trow;
    end
    if (col_neg) begin
      push_data.col = '0;
    end else if (tcol >= eff_cols) begin
      push_data.col = tccs_pkg::TGT_W'(eff_cols - 1'b1);
    end else begin
      push_data.col = tcol;
    end
    push_data.rd_ok = !row_neg && !col_neg && (trow < eff_rows) && (tcol < eff_cols);
  end
endmodule
`default_nettype wire

// File: hdl/tccs_queue.sv
// two entry command queue between front end and back end
// depends on tccs_pkg
`default_nettype none
module tccs_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tccs_pkg::cmd_t push_data,
  input  wire logic           pop,
  output logic                full,
  output logic                nonempty,
  output tccs_pkg::cmd_t      head
);
  tccs_pkg::cmd_t slots [2];
  logic           wp, rp;
  logic [1:0]     count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign head     = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_data;
    end
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// File: hdl/tccs_back.sv
// back end: executes commands on the cursor, colour and cell store
// depends on tccs_pkg, tccs_rsp_if and tccs_ram
`default_nettype none
module tccs_back #(
  parameter int MAX_COLUMNS = tccs_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tccs_pkg::MAX_ROWS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             q_valid,
  input  wire tccs_pkg::cmd_t                   q_data,
  output logic                                  q_pop,
  input  wire logic [$clog2(MAX_ROWS+1)-1:0]    eff_rows,
  input  wire logic [$clog2(MAX_COLUMNS+1)-1:0] eff_cols,
  output logic                                  init_done,
  tccs_rsp_if.source                            rsp
);
  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(DEPTH + 1);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_COPY = 3'd3;
  localparam logic [2:0] S_FILL = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]    state;
  logic [PW-1:0] ptr, wr_addr, area, body;
  logic          pend;
  logic [RW-1:0] crow, mrow;
  logic [CW-1:0] ccol, mcol;
  logic [CW:0]   next_col;
  logic [7:0]    attr;
  logic [15:0]   rd_cell;
  logic [PW-1:0] lin;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;
  logic          wrap;

  assign init_done = (state != S_INIT);
  assign q_pop     = (state == S_IDLE) && q_valid;

  // one shared multiplier: read address, write address and result address
  always_comb begin
    if ((state == S_IDLE) && (q_data.op == tccs_pkg::OP_READ)) begin
      mrow = RW'(q_data.row);
      mcol = CW'(q_data.col);
    end else begin
      mrow = crow;
      mcol = ccol;
    end
    lin = PW'(mrow) * PW'(eff_cols) + PW'(mcol);
  end

  always_comb begin
    if (q_data.op == tccs_pkg::OP_TAB) begin
      next_col = ((CW+1)'(ccol) + (CW+1)'(8)) & ~(CW+1)'(7);
    end else begin
      next_col = (CW+1)'(ccol) + 1'b1;
    end
    wrap = (q_data.op == tccs_pkg::OP_LF) || (next_col >= eff_cols);
  end

  always_comb begin
    we    = 1'b0;
    waddr = AW'(ptr);
    wdata = {attr, tccs_pkg::CH_SPACE};
    raddr = AW'(lin);
    case (state)
      S_INIT: begin
        we    = 1'b1;
        wdata = tccs_pkg::CELL_RESET;
      end
      S_IDLE: begin
        we    = q_valid && (q_data.op == tccs_pkg::OP_PUT);
        waddr = AW'(lin);
        wdata = {attr, q_data.chr};
      end
      S_COPY: begin
        we    = pend;
        waddr = AW'(wr_addr);
        wdata = rdata;
        raddr = AW'(ptr + PW'(eff_cols));
      end
      S_FILL: we = 1'b1;
      default: we = 1'b0;
    endcase
  end

  tccs_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    area <= PW'(eff_rows) * PW'(eff_cols);
    body <= area - PW'(eff_cols);
    if (rst) begin
      state     <= S_INIT;
      ptr       <= '0;
      pend      <= 1'b0;
      crow      <= '0;
      ccol      <= '0;
      attr      <= tccs_pkg::ATTR_RESET;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          ptr <= ptr + 1'b1;
          if (ptr == PW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            rd_cell <= '0;
            state   <= S_EMIT;
            case (q_data.op)
              tccs_pkg::OP_COLOUR: attr <= q_data.attr;
              tccs_pkg::OP_MOVE: begin
                crow <= RW'(q_data.row);
                ccol <= CW'(q_data.col);
              end
              tccs_pkg::OP_CR: ccol <= '0;
              tccs_pkg::OP_BS: begin
                if (ccol != '0) begin
                  ccol <= ccol - 1'b1;
                end
              end
              tccs_pkg::OP_READ: begin
                if (q_data.rd_ok) begin
                  state <= S_READ;
                end
              end
              tccs_pkg::OP_CLEAR: begin
                crow  <= '0;
                ccol  <= '0;
                ptr   <= '0;
                state <= S_FILL;
              end
              tccs_pkg::OP_PUT, tccs_pkg::OP_LF, tccs_pkg::OP_TAB: begin
                if (wrap) begin
                  ccol <= '0;
                  if ((RW+1)'(crow) + 1'b1 >= eff_rows) begin
                    // bottom reached: scroll up one row
                    ptr   <= '0;
                    pend  <= 1'b0;
                    state <= S_COPY;
                  end else begin
                    crow <= crow + 1'b1;
                  end
                end else begin
                  ccol <= CW'(next_col);
                end
              end
              default: attr <= attr;
            endcase
          end else begin
            // keeps the cursor inside a changed geometry
            if (crow >= eff_rows) begin
              crow <= RW'(eff_rows - 1'b1);
            end
            if (ccol >= eff_cols) begin
              ccol <= CW'(eff_cols - 1'b1);
            end
          end
        end
        S_READ: begin
          rd_cell <= rdata;
          state   <= S_EMIT;
        end
        S_COPY: begin
          // read one row below, write it in the next cycle
          if (ptr < body) begin
            wr_addr <= ptr;
            pend    <= 1'b1;
            ptr     <= ptr + 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_FILL;
            end
          end
        end
        S_FILL: begin
          ptr <= ptr + 1'b1;
          if (ptr + 1'b1 >= area) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && (!rsp.valid || rsp.ready)) begin
      rsp.cursor_row     <= 6'(crow);
      rsp.cursor_col     <= 7'(ccol);
      rsp.cursor_linear  <= 13'(lin);
      rsp.cell_value     <= rd_cell;
      rsp.current_colour <= attr;
    end
  end
endmodule
`default_nettype wire

// File: hdl/text_console_cursor_scroll_engine.sv
// text console engine top: apb geometry registers, front end, queue, back end
// depends on tccs_pkg, tccs_cmd_if, tccs_rsp_if, tccs_front, tccs_queue, tccs_back
// the back end works on one item at a time and takes the next from the queue only once
//   the result of the last has been issued; a cell read adds a read state
// scroll adds a copy pass and a fill pass, clear adds a fill pass over rows*columns cells
// reset starts a clearing pass over MAX_COLUMNS*MAX_ROWS cells (8192 by default)
//   during which no item is taken
`default_nettype none
module text_console_cursor_scroll_engine #(
  parameter int MAX_COLUMNS = tccs_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tccs_pkg::MAX_ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  tccs_cmd_if.sink         cmd,
  tccs_rsp_if.source       rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int NRW = $clog2(MAX_ROWS + 1);
  localparam int NCW = $clog2(MAX_COLUMNS + 1);

  logic [7:0]     screen_columns;
  logic [6:0]     text_rows;
  logic [NRW-1:0] eff_rows;
  logic [NCW-1:0] eff_cols;
  logic           init_done, q_full, q_valid, q_pop, push;
  tccs_pkg::cmd_t push_data, q_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == tccs_pkg::REG_ROWS) ? {25'd0, text_rows}
                                                   : {24'd0, screen_columns};

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_columns <= tccs_pkg::COLS_RESET;
      text_rows      <= tccs_pkg::ROWS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == tccs_pkg::REG_COLUMNS) begin
        screen_columns <= pwdata[7:0];
      end else begin
        text_rows <= pwdata[6:0];
      end
    end
  end

  // zero acts as one, values above the maximum act as the maximum
  always_comb begin
    if (screen_columns == '0) begin
      eff_cols = NCW'(1);
    end else if (int'(screen_columns) > MAX_COLUMNS) begin
      eff_cols = NCW'(MAX_COLUMNS);
    end else begin
      eff_cols = NCW'(screen_columns);
    end
    if (text_rows == '0) begin
      eff_rows = NRW'(1);
    end else if (int'(text_rows) > MAX_ROWS) begin
      eff_rows = NRW'(MAX_ROWS);
    end else begin
      eff_rows = NRW'(text_rows);
    end
  end

  tccs_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_front (
    .cmd       (cmd),
    .en        (init_done),
    .q_full    (q_full),
    .eff_rows  (eff_rows),
    .eff_cols  (eff_cols),
    .push      (push),
    .push_data (push_data)
  );

  tccs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .full      (q_full),
    .nonempty  (q_valid),
    .head      (q_data)
  );

  tccs_back #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .eff_rows  (eff_rows),
    .eff_cols  (eff_cols),
    .init_done (init_done),
    .rsp       (rsp)
  );
endmodule
`default_nettype wire
